/* src/aes_pkg.sv */
// AES-128 package: S-box table, GF(2^8) helpers and round functions.
// Used by aes_round and aes128_encrypt_and_match; depends on nothing.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned AddrWidth = 5;

  typedef logic [127:0] block_t;
  typedef logic [7:0] byte_t;

  // Register byte addresses (8 bytes apart, 64-bit registers).
  localparam logic [AddrWidth-1:0] AddrPlainHigh    = 5'h00;
  localparam logic [AddrWidth-1:0] AddrPlainLow     = 5'h08;
  localparam logic [AddrWidth-1:0] AddrExpectedHigh = 5'h10;
  localparam logic [AddrWidth-1:0] AddrExpectedLow  = 5'h18;

  // Forward S-box.
  function automatic byte_t sbox(input byte_t x);
    byte_t r;
    case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Multiplication by x in GF(2^8).
  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a block, byte 0 in the top bits.
  function automatic byte_t get_byte(input block_t s, input int unsigned n);
    return s[127 - 8*n -: 8];
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns.
  function automatic block_t round_fn(input block_t s, input logic last);
    byte_t t [16];
    byte_t a0, a1, a2, a3, all;
    block_t r;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[k + 4*c] = sbox(get_byte(s, k + 4*((c + k) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int n = 0; n < 16; n++) begin
      r[127 - 8*n -: 8] = t[n];
    end
    return r;
  endfunction

  // Next round key from the previous one and its round constant.
  function automatic block_t next_key(input block_t k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

/* src/aes_round.sv */
// One registered AES round with its key schedule step.
// Depends on aes_pkg.
module aes_round #(
  parameter logic [7:0] Rcon = 8'h01,
  parameter bit Last = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  aes_pkg::block_t in_state,
  input  aes_pkg::block_t in_key,
  output logic            out_valid,
  output aes_pkg::block_t out_state,
  output aes_pkg::block_t out_key
);

  aes_pkg::block_t key_next;

  // Round key for this round, used at once and passed on.
  assign key_next = aes_pkg::next_key(in_key, Rcon);

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_state <= aes_pkg::round_fn(in_state, Last) ^ key_next;
    out_key   <= key_next;
  end

endmodule

/* src/aes128_encrypt_and_match.sv */
// Top level: AES-128 encryption of a configured block with a fresh key per beat.
// Depends on aes_pkg and aes_round.
//
// Usage: raise start with key_high/key_low; busy is always low, so a key is
// taken every cycle. Each beat moves through an initial key-add stage, ten
// round stages and a compare stage; the result appears on cipher_high,
// cipher_low and match, marked by done for exactly one cycle. Throughput is
// one key per cycle, set by the fully unrolled round pipeline (one round with
// its key expansion step per stage).
// The receiver cannot stall; results are emitted in acceptance order.
// Configuration goes through the APB port: plain_high at 0x00, plain_low at
// 0x08, expected_high at 0x10, expected_low at 0x18, 64-bit data; other
// addresses are ignored. Write the registers only while no beat is in flight.
// Reset clears all four registers and empties the pipeline.
module aes128_encrypt_and_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  output logic        match,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [aes_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [7:0] RconList [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                           8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0] plain_high, plain_low, expected_high, expected_low;
  logic            stg_valid [11];
  aes_pkg::block_t stg_state [11];
  aes_pkg::block_t stg_key   [11];
  logic            wr_en;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      plain_high    <= '0;
      plain_low     <= '0;
      expected_high <= '0;
      expected_low  <= '0;
    end else if (wr_en) begin
      case (paddr)
        aes_pkg::AddrPlainHigh:    plain_high    <= pwdata;
        aes_pkg::AddrPlainLow:     plain_low     <= pwdata;
        aes_pkg::AddrExpectedHigh: expected_high <= pwdata;
        aes_pkg::AddrExpectedLow:  expected_low  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr)
      aes_pkg::AddrPlainHigh:    prdata = plain_high;
      aes_pkg::AddrPlainLow:     prdata = plain_low;
      aes_pkg::AddrExpectedHigh: prdata = expected_high;
      aes_pkg::AddrExpectedLow:  prdata = expected_low;
      default:                   prdata = '0;
    endcase
  end

  // Initial key addition stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else begin
      stg_valid[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    stg_state[0] <= {plain_high, plain_low} ^ {key_high, key_low};
    stg_key[0]   <= {key_high, key_low};
  end

  // Ten round stages.
  for (genvar g = 0; g < aes_pkg::NumRounds; g++) begin : g_round
    aes_round #(
      .Rcon (RconList[g]),
      .Last (g == aes_pkg::NumRounds - 1)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_state  (stg_state[g]),
      .in_key    (stg_key[g]),
      .out_valid (stg_valid[g+1]),
      .out_state (stg_state[g+1]),
      .out_key   (stg_key[g+1])
    );
  end

  // Compare and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg_valid[10];
    end
  end

  always_ff @(posedge clk) begin
    cipher_high <= stg_state[10][127:64];
    cipher_low  <= stg_state[10][63:0];
    match       <= (stg_state[10] == {expected_high, expected_low});
  end

endmodule
